FILE: rtl/core/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, codes and match tables for the HTTP response stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

	// item kinds carried on the input tuser
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_INVALID = 2'd1;
	localparam logic [1:0] ERR_TIMEOUT = 2'd2;

	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_WILD = "*";

	localparam int STATUS_LEN = 9;
	localparam int CL_LEN     = 16;
	localparam int TE_LEN     = 26;

	localparam logic [8*STATUS_LEN-1:0] STATUS_TEXT = "HTTP/*.* ";
	localparam logic [8*CL_LEN-1:0]     CL_TEXT     = "Content-Length: ";
	localparam logic [8*TE_LEN-1:0]     TE_TEXT     = "Transfer-Encoding: chunked";

	localparam logic [9:0]  STATUS_MAX      = 10'd999;
	localparam logic [9:0]  STATUS_OK_MIN   = 10'd200;
	localparam logic [9:0]  STATUS_SWITCH   = 10'd101;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd30000;
	localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

	// short queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam int OUT_TDATA_W = 96;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_STATUS = 4'd1,
		PH_CODE   = 4'd2,
		PH_REST   = 4'd3,
		PH_LINE   = 4'd4,
		PH_LEN    = 4'd5,
		PH_SKIP   = 4'd6,
		PH_CR     = 4'd7,
		PH_BODY   = 4'd8,
		PH_CHLEN  = 4'd9,
		PH_CHDATA = 4'd10,
		PH_ERROR  = 4'd11
	} phase_t;

	// classified input word
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_hex;
		logic [3:0] hex;
		logic       is_lf;
		logic       is_cr;
	} item_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        is_body;
		logic [3:0]  phase;
		logic [9:0]  status_value;
		logic [31:0] body_length;
		logic        has_length;
		logic        is_chunked;
		logic [31:0] consumed_count;
		logic        body_done;
		logic [1:0]  error_code;
	} result_t;

	function automatic logic [7:0] status_char(input logic [3:0] pos);
		logic [7:0] ch;
		ch = 8'd0;
		if (int'(pos) < STATUS_LEN) begin
			ch = STATUS_TEXT[8*(STATUS_LEN-1-int'(pos)) +: 8];
		end
		return ch;
	endfunction

	function automatic logic [7:0] cl_char(input logic [4:0] pos);
		logic [7:0] ch;
		ch = 8'd0;
		if (int'(pos) < CL_LEN) begin
			ch = CL_TEXT[8*(CL_LEN-1-int'(pos)) +: 8];
		end
		return ch;
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] pos);
		logic [7:0] ch;
		ch = 8'd0;
		if (int'(pos) < TE_LEN) begin
			ch = TE_TEXT[8*(TE_LEN-1-int'(pos)) +: 8];
		end
		return ch;
	endfunction

endpackage

FILE: rtl/core/hrsp_front.sv
// ----------------------------------------------------------------------------
// hrsp_front
// Input side: takes words while the queue has room and classifies each byte.
// ----------------------------------------------------------------------------
module hrsp_front (
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,
	input  logic [1:0]        s_axis_tuser,
	input  logic              q_full,
	output logic              push,
	output hrsp_pkg::item_t   item
);

	logic [7:0] c;

	assign c             = s_axis_tdata;
	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		item          = '0;
		item.op       = s_axis_tuser;
		item.data     = c;
		item.is_lf    = (c == hrsp_pkg::CHAR_LF);
		item.is_cr    = (c == hrsp_pkg::CHAR_CR);
		item.is_digit = (c >= "0") && (c <= "9");
		item.digit    = 4'(c - 8'("0"));
		if (c >= "0" && c <= "9") begin
			item.is_hex = 1'b1;
			item.hex    = 4'(c - 8'("0"));
		end else if (c >= "a" && c <= "f") begin
			item.is_hex = 1'b1;
			item.hex    = 4'(c - 8'("a") + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			item.is_hex = 1'b1;
			item.hex    = 4'(c - 8'("A") + 8'd10);
		end
	end

endmodule

FILE: rtl/core/hrsp_queue.sv
// ----------------------------------------------------------------------------
// hrsp_queue
// Small FIFO of classified words between the front and the parser.
// ----------------------------------------------------------------------------
module hrsp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hrsp_pkg::item_t   push_item,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output hrsp_pkg::item_t   head_item
);

	hrsp_pkg::item_t                 slot_q [hrsp_pkg::QUEUE_DEPTH];
	logic [hrsp_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [hrsp_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [hrsp_pkg::QPTR_W:0]       count_q;

	assign full      = (count_q == (hrsp_pkg::QPTR_W+1)'(hrsp_pkg::QUEUE_DEPTH));
	assign q_valid   = (count_q != '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/hrsp_back.sv
// ----------------------------------------------------------------------------
// hrsp_back
// Parser state machine: status line, headers, body and chunk counting,
// with a result register toward the output channel.
// ----------------------------------------------------------------------------
module hrsp_back #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                q_valid,
	input  hrsp_pkg::item_t     it,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output hrsp_pkg::result_t   out_res
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	hrsp_pkg::phase_t         phase_q, phase_n;
	logic [9:0]               status_q, status_n;
	logic [3:0]               spos_q, spos_n;
	logic [4:0]               lpos_q, lpos_n;
	logic [4:0]               epos_q, epos_n;
	logic [COUNT_WIDTH-1:0]   len_q, len_n;
	logic                     len_seen_q, len_seen_n;
	logic                     chunked_q, chunked_n;
	logic [COUNT_WIDTH-1:0]   cons_q, cons_n;
	logic [COUNT_WIDTH-1:0]   rem_q, rem_n;
	logic [15:0]              idle_q, idle_n;
	logic [1:0]               err_q, err_n;
	logic [15:0]              timeout_q;

	logic                     out_valid_q;
	hrsp_pkg::result_t        res_q;
	hrsp_pkg::result_t        res_n;

	logic                     in_hdr;
	logic                     status_hit;
	logic [13:0]              status_sum;
	logic [COUNT_WIDTH+3:0]   len_sum;
	logic [COUNT_WIDTH-1:0]   len_sat;
	logic [COUNT_WIDTH-1:0]   rem_sat;
	logic [COUNT_WIDTH-1:0]   cons_inc;
	logic [15:0]              idle_inc;
	logic [15:0]              limit;
	logic                     body;
	logic [COUNT_WIDTH+31:0]  len_ext;
	logic [COUNT_WIDTH+31:0]  cons_ext;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// shared arithmetic
	assign in_hdr     = (phase_q >= hrsp_pkg::PH_STATUS) && (phase_q <= hrsp_pkg::PH_CR);
	assign status_hit = (int'(spos_q) < hrsp_pkg::STATUS_LEN) &&
	                    ((hrsp_pkg::status_char(spos_q) == hrsp_pkg::CHAR_WILD) ||
	                     (hrsp_pkg::status_char(spos_q) == it.data));
	assign status_sum = {1'b0, status_q, 3'b000} + {3'b000, status_q, 1'b0} +
	                    {10'd0, it.digit};
	assign len_sum    = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} +
	                    {COUNT_WIDTH'(0), it.digit};
	assign len_sat    = (len_sum[COUNT_WIDTH+3:COUNT_WIDTH] != '0) ? CNT_MAX
	                                                               : len_sum[COUNT_WIDTH-1:0];
	assign rem_sat    = (rem_q[COUNT_WIDTH-1:COUNT_WIDTH-4] != '0) ? CNT_MAX
	                                                               : {rem_q[COUNT_WIDTH-5:0], it.hex};
	assign cons_inc   = (len_seen_q && (len_q != '0) && (cons_q != CNT_MAX)) ? cons_q + 1'b1
	                                                                         : cons_q;
	assign idle_inc   = (idle_q == hrsp_pkg::IDLE_MAX) ? idle_q : idle_q + 1'b1;
	assign limit      = (timeout_q == '0) ? 16'd1 : timeout_q;

	// next state
	always_comb begin
		phase_n    = phase_q;
		status_n   = status_q;
		spos_n     = spos_q;
		lpos_n     = lpos_q;
		epos_n     = epos_q;
		len_n      = len_q;
		len_seen_n = len_seen_q;
		chunked_n  = chunked_q;
		cons_n     = cons_q;
		rem_n      = rem_q;
		idle_n     = idle_q;
		err_n      = err_q;
		case (it.op)
			hrsp_pkg::OP_BEGIN: begin
				phase_n    = hrsp_pkg::PH_STATUS;
				status_n   = '0;
				spos_n     = '0;
				lpos_n     = '0;
				epos_n     = '0;
				len_n      = '0;
				len_seen_n = 1'b0;
				chunked_n  = 1'b0;
				cons_n     = '0;
				rem_n      = '0;
				idle_n     = '0;
				err_n      = hrsp_pkg::ERR_NONE;
			end
			hrsp_pkg::OP_BYTE: begin
				if (in_hdr) begin
					idle_n = '0;
				end
				case (phase_q)
					hrsp_pkg::PH_STATUS: begin
						if (status_hit) begin
							spos_n = spos_q + 1'b1;
							if (int'(spos_q) == hrsp_pkg::STATUS_LEN - 1) begin
								phase_n = hrsp_pkg::PH_CODE;
							end
						end else begin
							phase_n = hrsp_pkg::PH_ERROR;
							err_n   = hrsp_pkg::ERR_INVALID;
						end
					end
					hrsp_pkg::PH_CODE, hrsp_pkg::PH_REST: begin
						if (phase_q == hrsp_pkg::PH_CODE && it.is_digit) begin
							status_n = (status_sum > 14'(hrsp_pkg::STATUS_MAX))
							           ? hrsp_pkg::STATUS_MAX : status_sum[9:0];
						end else begin
							phase_n = hrsp_pkg::PH_REST;
							if (it.is_lf) begin
								// interim responses restart at the status line
								if (status_q < hrsp_pkg::STATUS_OK_MIN &&
								    status_q != hrsp_pkg::STATUS_SWITCH) begin
									phase_n  = hrsp_pkg::PH_STATUS;
									status_n = '0;
									spos_n   = '0;
								end else begin
									phase_n = hrsp_pkg::PH_LINE;
									lpos_n  = '0;
									epos_n  = '0;
								end
							end
						end
					end
					hrsp_pkg::PH_LINE: begin
						if (int'(lpos_q) < hrsp_pkg::CL_LEN &&
						    hrsp_pkg::cl_char(lpos_q) == it.data) begin
							lpos_n = lpos_q + 1'b1;
							if (int'(lpos_q) == hrsp_pkg::CL_LEN - 1) begin
								phase_n    = hrsp_pkg::PH_LEN;
								len_n      = '0;
								cons_n     = '0;
								len_seen_n = 1'b1;
							end
						end else if (int'(epos_q) < hrsp_pkg::TE_LEN &&
						             hrsp_pkg::te_char(epos_q) == it.data) begin
							epos_n = epos_q + 1'b1;
							if (int'(epos_q) == hrsp_pkg::TE_LEN - 1) begin
								chunked_n = 1'b1;
								phase_n   = hrsp_pkg::PH_SKIP;
							end
						end else if (lpos_q == '0 && epos_q == '0 && it.is_cr) begin
							phase_n = hrsp_pkg::PH_CR;
						end else begin
							phase_n = hrsp_pkg::PH_SKIP;
						end
					end
					hrsp_pkg::PH_LEN: begin
						if (it.is_digit) begin
							len_n = len_sat;
						end else begin
							phase_n = hrsp_pkg::PH_SKIP;
						end
					end
					hrsp_pkg::PH_CR: begin
						if (it.is_lf) begin
							if (chunked_q) begin
								phase_n = hrsp_pkg::PH_CHLEN;
								rem_n   = '0;
							end else begin
								phase_n = hrsp_pkg::PH_BODY;
							end
						end
					end
					hrsp_pkg::PH_BODY: begin
						cons_n = cons_inc;
					end
					hrsp_pkg::PH_CHLEN: begin
						if (it.is_lf) begin
							phase_n = (rem_q == '0) ? hrsp_pkg::PH_CHLEN : hrsp_pkg::PH_CHDATA;
						end else if (it.is_hex) begin
							rem_n = rem_sat;
						end
					end
					hrsp_pkg::PH_CHDATA: begin
						cons_n = cons_inc;
						if (rem_q != '0) begin
							rem_n = rem_q - 1'b1;
						end
						if (rem_q <= COUNT_WIDTH'(1)) begin
							phase_n = hrsp_pkg::PH_CHLEN;
						end
					end
					default: begin
					end
				endcase
				// any LF inside the headers starts a new header line
				if (it.is_lf && phase_n >= hrsp_pkg::PH_LINE && phase_n <= hrsp_pkg::PH_CR) begin
					phase_n = hrsp_pkg::PH_LINE;
					lpos_n  = '0;
					epos_n  = '0;
				end
			end
			hrsp_pkg::OP_TICK: begin
				if (in_hdr) begin
					idle_n = idle_inc;
					if (idle_inc >= limit) begin
						phase_n = hrsp_pkg::PH_ERROR;
						err_n   = hrsp_pkg::ERR_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result word
	assign body     = (it.op == hrsp_pkg::OP_BYTE) &&
	                  (phase_q == hrsp_pkg::PH_BODY || phase_q == hrsp_pkg::PH_CHDATA);
	assign len_ext  = {32'd0, len_n};
	assign cons_ext = {32'd0, cons_n};

	always_comb begin
		res_n                = '0;
		res_n.byte_out       = (it.op == hrsp_pkg::OP_BYTE) ? it.data : 8'd0;
		res_n.is_body        = body;
		res_n.phase          = phase_n;
		res_n.status_value   = status_n;
		res_n.body_length    = len_ext[31:0];
		res_n.has_length     = len_seen_n;
		res_n.is_chunked     = chunked_n;
		res_n.consumed_count = cons_ext[31:0];
		res_n.body_done      = (phase_n >= hrsp_pkg::PH_BODY) &&
		                       (phase_n <= hrsp_pkg::PH_CHDATA) &&
		                       len_seen_n && (cons_n >= len_n);
		res_n.error_code     = err_n;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hrsp_pkg::PH_IDLE;
			status_q    <= '0;
			spos_q      <= '0;
			lpos_q      <= '0;
			epos_q      <= '0;
			len_q       <= '0;
			len_seen_q  <= 1'b0;
			chunked_q   <= 1'b0;
			cons_q      <= '0;
			rem_q       <= '0;
			idle_q      <= '0;
			err_q       <= hrsp_pkg::ERR_NONE;
			timeout_q   <= hrsp_pkg::TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (pop) begin
				phase_q    <= phase_n;
				status_q   <= status_n;
				spos_q     <= spos_n;
				lpos_q     <= lpos_n;
				epos_q     <= epos_n;
				len_q      <= len_n;
				len_seen_q <= len_seen_n;
				chunked_q  <= chunked_n;
				cons_q     <= cons_n;
				rem_q      <= rem_n;
				idle_q     <= idle_n;
				err_q      <= err_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/http_response_stream_parser.sv
// ----------------------------------------------------------------------------
// http_response_stream_parser
// Streaming HTTP/1.1 response parser: status line, headers, plain and
// chunked body, with idle timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a kind in s_axis_tuser (begin response, received byte,
//   timer tick) and the byte in s_axis_tdata. Send a begin word before each
//   response, then bytes as they arrive and ticks from a slow timer.
//   Every input word yields exactly one output word on m_axis, in order,
//   carrying the byte, the current parse phase, status code, content length,
//   chunked flag, consumed body count, done flag and error code.
//   A word accepted on s_axis is written into the 4-entry queue, then parsed
//   into the result register when that register is free, which drives m_axis.
//   Throughput: one word per cycle while m_axis is not stalled; the parser
//   handles each word with combinational compares and accumulates.
//   A stalled m_axis_tready holds the result register; the queue absorbs
//   up to four more words, after which s_axis_tready drops.
//   cfg_wr_en/cfg_wr_data write the timeout in ticks (0 acts as 1); write
//   it only while the block is idle.
//   Reset clears the parser to the idle phase, empties the queue and loads
//   the timeout with 30000.
// ----------------------------------------------------------------------------
module http_response_stream_parser #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,   // response_timeout_ticks
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [hrsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	                                   // [7:0] byte_out, [11:8] phase,
	                                   // [21:12] status_value, [53:22] body_length,
	                                   // [54] has_length, [55] is_chunked,
	                                   // [87:56] consumed_count, [88] body_done,
	                                   // [90:89] error_code, [95:91] zero
	output logic        m_axis_tuser   // [0] is_body
);

	logic               push;
	logic               q_full;
	logic               q_valid;
	logic               pop;
	hrsp_pkg::item_t    front_item;
	hrsp_pkg::item_t    head_item;
	hrsp_pkg::result_t  res;

	// front: accept and classify
	hrsp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.item          (front_item)
	);

	// decouples input acceptance from output stalls
	hrsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.head_item (head_item)
	);

	// back: parser and result register
	hrsp_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.it          (head_item),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res)
	);

	// pack result fields, lowest field first
	assign m_axis_tuser = res.is_body;
	assign m_axis_tdata = {5'd0, res.error_code, res.body_done, res.consumed_count,
	                       res.is_chunked, res.has_length, res.body_length,
	                       res.status_value, res.phase, res.byte_out};

endmodule

FILE: rtl/core/hrsp_checker.sv
// ----------------------------------------------------------------------------
// hrsp_checker
// Port-level checks on the parser output channel.
// ----------------------------------------------------------------------------
module hrsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// error code set exactly in the error phase
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		((m_axis_tdata[90:89] != hrsp_pkg::ERR_NONE) == (m_axis_tdata[11:8] == hrsp_pkg::PH_ERROR)))
		else $error("error code and phase disagree");

	// body bytes only from body or chunk phases
	a_body_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		(m_axis_tdata[11:8] == hrsp_pkg::PH_BODY || m_axis_tdata[11:8] == hrsp_pkg::PH_CHLEN ||
		 m_axis_tdata[11:8] == hrsp_pkg::PH_CHDATA))
		else $error("body byte outside body phases");

	// done needs a known length
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[88] |-> m_axis_tdata[54])
		else $error("body done without content length");

endmodule

bind http_response_stream_parser hrsp_checker u_hrsp_checker (.*);
